// ===== hdl/counting_semaphore_table_macros.svh =====
// Assertion macros for the semaphore table.
`ifndef COUNTING_SEMAPHORE_TABLE_MACROS_SVH
`define COUNTING_SEMAPHORE_TABLE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define CST_ASSERT_IMPLY(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("semaphore table: implication check failed");
// next-cycle implication
`define CST_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("semaphore table: next-cycle check failed");
`else
`define CST_ASSERT_IMPLY(lbl, clk, rst, a, b)
`define CST_ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

// ===== hdl/cst_pkg.sv =====
// Shared constants, types and address helpers of the semaphore table.
package cst_pkg;
   localparam int NUM_SLOTS  = 16;
   localparam int NUM_PROCS  = 16;
   localparam int COUNT_BITS = 16;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int PROC_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam int LEN_W  = $clog2(NUM_PROCS + 1);
   localparam int ADDR_W = $clog2(NUM_SLOTS * NUM_PROCS);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [2:0] FUNC_OPEN  = 3'd0;
   localparam logic [2:0] FUNC_CLOSE = 3'd1;
   localparam logic [2:0] FUNC_WAIT  = 3'd2;
   localparam logic [2:0] FUNC_POST  = 3'd3;
   localparam logic [2:0] FUNC_RESET = 3'd4;
   localparam logic [2:0] FUNC_PURGE = 3'd5;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_BLOCK = 2'd1;
   localparam logic [1:0] ACT_WAKE  = 2'd2;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [PROC_W-1:0] qpid_type;

   // queue entry address: slot base plus (head + off) modulo NUM_PROCS
   function automatic addr_type fifo_addr(input logic [SLOT_W-1:0] slot,
                                          input logic [PROC_W-1:0] head,
                                          input logic [LEN_W-1:0]  off);
      logic [LEN_W:0] sum;
      sum = (LEN_W+1)'(head) + (LEN_W+1)'(off);
      if (sum >= (LEN_W+1)'(NUM_PROCS)) begin
         sum = sum - (LEN_W+1)'(NUM_PROCS);
      end
      return ADDR_W'(int'(slot) * NUM_PROCS + int'(sum));
   endfunction

   function automatic logic [PROC_W-1:0] head_inc(input logic [PROC_W-1:0] head);
      logic [PROC_W:0] sum;
      sum = (PROC_W+1)'(head) + (PROC_W+1)'(1);
      if (sum >= (PROC_W+1)'(NUM_PROCS)) begin
         sum = '0;
      end
      return sum[PROC_W-1:0];
   endfunction
endpackage

// ===== hdl/cst_if.sv =====
// Request and response channel interfaces of the semaphore table.
interface cst_req_if import cst_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [31:0] sem_key;
   logic [3:0]  pid;
   logic [15:0] count_value;
   logic        caller_blocked;

   modport source (output valid, func, sem_key, pid, count_value, caller_blocked,
                   input ready);
   modport sink   (input valid, func, sem_key, pid, count_value, caller_blocked,
                   output ready);
endinterface

interface cst_rsp_if import cst_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       status;
   logic [1:0] action;
   logic [3:0] target_pid;
   logic       last;

   modport source (output valid, status, action, target_pid, last, input ready);
   modport sink   (input valid, status, action, target_pid, last, output ready);
endinterface

// ===== hdl/counting_semaphore_table.sv =====
// Top level of the counting semaphore table with per-slot FIFO wait queues.
//
//  channel | dir | handshake     | word
//  req_if  | in  | valid/ready   | func, sem_key, pid, count_value, caller_blocked
//  rsp_if  | out | valid/ready   | status, action, target_pid, last
//
// One request at a time under a sequencer. The slot table is scanned one slot
// a cycle, then the op runs: post may emit a wake word, reset emits one wake
// word per woken waiter; purge visits every slot and walks a queue entry by
// entry through the single-port read of the wait RAM. Reset is synchronous
// and clears slot valid bits, queue heads and lengths at once. A stalled
// response word only holds the sequencer where a new word must be loaded.
`include "counting_semaphore_table_macros.svh"
module counting_semaphore_table import cst_pkg::*; (
   input logic   clock,
   input logic   reset,
   cst_req_if.sink   req_if,
   cst_rsp_if.source rsp_if
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_SCAN, ST_EXEC, ST_POP, ST_RST_CHK,
      ST_PURGE_CHK, ST_RM_RD, ST_RM_CMP, ST_SH_RD, ST_SH_WR, ST_PURGE_CLOSE,
      ST_FINAL
   } state_type;

   state_type state_ff;

   // slot table, flip-flops, all reads at idx_ff
   logic                  slot_valid_ff [NUM_SLOTS];
   logic [31:0]           slot_key_ff   [NUM_SLOTS];
   logic [COUNT_BITS-1:0] slot_count_ff [NUM_SLOTS];
   logic [LEN_W-1:0]      slot_refs_ff  [NUM_SLOTS];
   logic [NUM_PROCS-1:0]  owner_ff      [NUM_SLOTS];
   logic [PROC_W-1:0]     head_ff       [NUM_SLOTS];
   logic [LEN_W-1:0]      len_ff        [NUM_SLOTS];

   // latched request
   logic [2:0]            func_ff;
   logic [31:0]           key_ff;
   logic [3:0]            pid_ff;
   logic [COUNT_BITS-1:0] val_ff;
   logic                  blocked_ff;

   // sequencer
   logic [SLOT_W-1:0] idx_ff;
   logic [SLOT_W-1:0] free_ff;
   logic              free_hit_ff;
   logic [LEN_W-1:0]  i_ff;

   // pending final word
   logic       fin_status_ff;
   logic [1:0] fin_action_ff;
   logic [3:0] fin_target_ff;

   // response register
   logic       rsp_valid_ff;
   logic       rsp_status_ff;
   logic [1:0] rsp_action_ff;
   logic [3:0] rsp_target_ff;
   logic       rsp_last_ff;

   // current slot
   logic                  cur_valid;
   logic                  cur_hit;
   logic                  cur_owned;
   logic [COUNT_BITS-1:0] cur_count;
   logic [LEN_W-1:0]      cur_len;
   logic [PROC_W-1:0]     cur_head;
   logic [NUM_PROCS-1:0]  pid_mask;
   logic                  pid_ok;
   logic                  out_free;
   logic                  rsp_load;
   logic                  last_slot;
   logic [COUNT_BITS-1:0] val_sat;
   logic                  i1_lt_len;
   logic                  i2_lt_len;

   // wait RAM hookup
   logic             wr_en;
   logic [LEN_W-1:0] rd_off;
   logic [LEN_W-1:0] wr_off;
   addr_type         rd_addr;
   addr_type         wr_addr;
   qpid_type         wr_data;
   qpid_type         rd_data;
   logic             do_close;

   assign cur_valid = slot_valid_ff[idx_ff];
   assign cur_count = slot_count_ff[idx_ff];
   assign cur_len   = len_ff[idx_ff];
   assign cur_head  = head_ff[idx_ff];
   assign pid_mask  = NUM_PROCS'(1) << pid_ff;
   assign cur_owned = |(owner_ff[idx_ff] & pid_mask);
   assign cur_hit   = cur_valid && (slot_key_ff[idx_ff] == key_ff);
   assign pid_ok    = int'(pid_ff) < NUM_PROCS;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   // a wake or final word goes into the response register this cycle
   assign rsp_load  = out_free && (state_ff == ST_POP || state_ff == ST_FINAL);
   assign last_slot = idx_ff == SLOT_W'(NUM_SLOTS - 1);
   assign i1_lt_len = (LEN_W+2)'(i_ff) + (LEN_W+2)'(1) < (LEN_W+2)'(cur_len);
   assign i2_lt_len = (LEN_W+2)'(i_ff) + (LEN_W+2)'(2) < (LEN_W+2)'(cur_len);

   assign val_sat = (32'(req_if.count_value) > 32'(COUNT_MAX)) ? COUNT_MAX
                                                               : COUNT_BITS'(req_if.count_value);

   assign req_if.ready = state_ff == ST_IDLE;

   // shift step reads one entry ahead of where it writes
   assign rd_off  = (state_ff == ST_SH_RD) ? LEN_W'(i_ff + LEN_W'(1)) : i_ff;
   assign wr_off  = (state_ff == ST_SH_WR) ? i_ff : cur_len;
   assign rd_addr = fifo_addr(idx_ff, cur_head, rd_off);
   assign wr_addr = fifo_addr(idx_ff, cur_head, wr_off);
   assign wr_data = (state_ff == ST_SH_WR) ? rd_data : PROC_W'(pid_ff);
   assign wr_en   = (state_ff == ST_SH_WR) ||
                    (state_ff == ST_EXEC && func_ff == FUNC_WAIT &&
                     cur_count == '0 && cur_len < LEN_W'(NUM_PROCS));
   assign do_close = (state_ff == ST_PURGE_CLOSE) ||
                     (state_ff == ST_EXEC && func_ff == FUNC_CLOSE);

   cst_wait_ram u_wait_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            slot_valid_ff[s] <= 1'b0;
            head_ff[s]       <= '0;
            len_ff[s]        <= '0;
         end
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  func_ff     <= req_if.func;
                  key_ff      <= req_if.sem_key;
                  pid_ff      <= req_if.pid;
                  val_ff      <= val_sat;
                  blocked_ff  <= req_if.caller_blocked;
                  idx_ff      <= '0;
                  free_hit_ff <= 1'b0;
                  i_ff        <= '0;
                  state_ff    <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               fin_status_ff <= 1'b0;
               fin_action_ff <= ACT_NONE;
               fin_target_ff <= '0;
               if (func_ff > FUNC_PURGE ||
                   (!pid_ok && (func_ff == FUNC_OPEN || func_ff == FUNC_CLOSE ||
                                func_ff == FUNC_WAIT || func_ff == FUNC_PURGE))) begin
                  fin_status_ff <= 1'b1;
                  state_ff      <= ST_FINAL;
               end else if (func_ff == FUNC_PURGE) begin
                  state_ff <= ST_PURGE_CHK;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (cur_hit) begin
                  state_ff <= ST_EXEC;
               end else begin
                  if (!cur_valid && !free_hit_ff) begin
                     free_ff     <= idx_ff;
                     free_hit_ff <= 1'b1;
                  end
                  if (last_slot) begin
                     state_ff <= ST_FINAL;
                     if (func_ff == FUNC_OPEN && (free_hit_ff || !cur_valid)) begin
                        // new semaphore in the lowest free slot
                        slot_valid_ff[free_hit_ff ? free_ff : idx_ff] <= 1'b1;
                        slot_key_ff[free_hit_ff ? free_ff : idx_ff]   <= key_ff;
                        slot_count_ff[free_hit_ff ? free_ff : idx_ff] <= val_ff;
                        slot_refs_ff[free_hit_ff ? free_ff : idx_ff]  <= LEN_W'(1);
                        owner_ff[free_hit_ff ? free_ff : idx_ff]      <= pid_mask;
                        head_ff[free_hit_ff ? free_ff : idx_ff]       <= '0;
                        len_ff[free_hit_ff ? free_ff : idx_ff]        <= '0;
                     end else begin
                        fin_status_ff <= 1'b1;
                     end
                  end else begin
                     idx_ff <= idx_ff + SLOT_W'(1);
                  end
               end
            end
            ST_EXEC: begin
               state_ff <= ST_FINAL;
               case (func_ff)
                  FUNC_OPEN: begin
                     if (cur_owned) begin
                        fin_status_ff <= 1'b1;
                     end else begin
                        owner_ff[idx_ff]     <= owner_ff[idx_ff] | pid_mask;
                        slot_refs_ff[idx_ff] <= slot_refs_ff[idx_ff] + LEN_W'(1);
                     end
                  end
                  FUNC_WAIT: begin
                     if (cur_count != '0) begin
                        slot_count_ff[idx_ff] <= cur_count - COUNT_BITS'(1);
                     end else if (cur_len >= LEN_W'(NUM_PROCS)) begin
                        fin_status_ff <= 1'b1;
                     end else begin
                        len_ff[idx_ff] <= cur_len + LEN_W'(1);
                        fin_action_ff  <= ACT_BLOCK;
                        fin_target_ff  <= pid_ff;
                     end
                  end
                  FUNC_POST: begin
                     if (cur_len != '0) begin
                        state_ff <= ST_POP;
                     end else if (cur_count != COUNT_MAX) begin
                        slot_count_ff[idx_ff] <= cur_count + COUNT_BITS'(1);
                     end
                  end
                  FUNC_RESET: begin
                     state_ff <= ST_RST_CHK;
                  end
                  default: begin
                     // close handled by do_close
                  end
               endcase
            end
            ST_RST_CHK: begin
               if (cur_len != '0 && val_ff != '0) begin
                  state_ff <= ST_POP;
               end else begin
                  slot_count_ff[idx_ff] <= val_ff;
                  state_ff              <= ST_FINAL;
               end
            end
            ST_POP: begin
               // head entry was read on the way in; emit it as a wake word
               if (out_free) begin
                  rsp_status_ff  <= 1'b0;
                  rsp_action_ff  <= ACT_WAKE;
                  rsp_target_ff  <= 4'(rd_data);
                  rsp_last_ff    <= 1'b0;
                  head_ff[idx_ff] <= head_inc(cur_head);
                  len_ff[idx_ff]  <= cur_len - LEN_W'(1);
                  if (func_ff == FUNC_RESET) begin
                     val_ff   <= val_ff - COUNT_BITS'(1);
                     state_ff <= ST_RST_CHK;
                  end else begin
                     state_ff <= ST_FINAL;
                  end
               end
            end
            ST_PURGE_CHK: begin
               i_ff <= '0;
               if (cur_valid && cur_owned) begin
                  state_ff <= (blocked_ff && cur_len != '0) ? ST_RM_RD : ST_PURGE_CLOSE;
               end else if (last_slot) begin
                  state_ff <= ST_FINAL;
               end else begin
                  idx_ff <= idx_ff + SLOT_W'(1);
               end
            end
            ST_RM_RD: begin
               state_ff <= ST_RM_CMP;
            end
            ST_RM_CMP: begin
               if (int'(rd_data) == int'(pid_ff)) begin
                  if (i1_lt_len) begin
                     state_ff <= ST_SH_RD;
                  end else begin
                     len_ff[idx_ff] <= cur_len - LEN_W'(1);
                     state_ff       <= ST_PURGE_CLOSE;
                  end
               end else if (i1_lt_len) begin
                  i_ff     <= i_ff + LEN_W'(1);
                  state_ff <= ST_RM_RD;
               end else begin
                  state_ff <= ST_PURGE_CLOSE;
               end
            end
            ST_SH_RD: begin
               state_ff <= ST_SH_WR;
            end
            ST_SH_WR: begin
               i_ff <= i_ff + LEN_W'(1);
               if (i2_lt_len) begin
                  state_ff <= ST_SH_RD;
               end else begin
                  len_ff[idx_ff] <= cur_len - LEN_W'(1);
                  state_ff       <= ST_PURGE_CLOSE;
               end
            end
            ST_PURGE_CLOSE: begin
               if (last_slot) begin
                  state_ff <= ST_FINAL;
               end else begin
                  idx_ff   <= idx_ff + SLOT_W'(1);
                  state_ff <= ST_PURGE_CHK;
               end
            end
            ST_FINAL: begin
               if (out_free) begin
                  rsp_status_ff <= fin_status_ff;
                  rsp_action_ff <= fin_action_ff;
                  rsp_target_ff <= fin_target_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         // leave the slot: last reference frees it and drops its waiters
         if (do_close) begin
            if (slot_refs_ff[idx_ff] > LEN_W'(1)) begin
               slot_refs_ff[idx_ff] <= slot_refs_ff[idx_ff] - LEN_W'(1);
               owner_ff[idx_ff]     <= owner_ff[idx_ff] & ~pid_mask;
            end else begin
               slot_valid_ff[idx_ff] <= 1'b0;
               len_ff[idx_ff]        <= '0;
               head_ff[idx_ff]       <= '0;
            end
         end
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.action     = rsp_action_ff;
   assign rsp_if.target_pid = rsp_target_ff;
   assign rsp_if.last       = rsp_last_ff;

   // busy straight after taking a request
   `CST_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_if.valid && req_if.ready, !req_if.ready)
   // only wake words come before the final word
   `CST_ASSERT_IMPLY(a_wake_not_last, clock, reset, rsp_if.valid && !rsp_if.last, rsp_if.action == ACT_WAKE && !rsp_if.status)
   // a block request is always a final, successful word
   `CST_ASSERT_IMPLY(a_block_final, clock, reset, rsp_if.valid && rsp_if.action == ACT_BLOCK, rsp_if.last && !rsp_if.status)
endmodule

// ===== hdl/cst_wait_ram.sv =====
// Wait-queue storage: one write port, one registered read port.
module cst_wait_ram import cst_pkg::*; (
   input  logic     clock,
   input  logic     wr_en,
   input  addr_type wr_addr,
   input  qpid_type wr_data,
   input  addr_type rd_addr,
   output qpid_type rd_data
);
   qpid_type mem [NUM_SLOTS*NUM_PROCS];
   qpid_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== verif/cst_tb_if.sv =====
// Shared testbench types of the semaphore table.
package cst_tb_pkg;
   typedef struct packed {
      logic       status;
      logic [1:0] action;
      logic [3:0] target_pid;
      logic       last;
   } rsp_word_type;
endpackage

// ===== verif/tb_counting_semaphore_table.sv =====
// Testbench of the counting semaphore table: random and directed requests, scoreboard check.
module tb_counting_semaphore_table;
   import cst_pkg::*;
   import cst_tb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Predicted response words, oldest first, with the table shadow that produces them.
   class sem_scoreboard;
      rsp_word_type  pending[$];
      bit         s_valid[NUM_SLOTS];
      logic [31:0] s_key[NUM_SLOTS];
      int unsigned s_count[NUM_SLOTS];
      int unsigned s_refs[NUM_SLOTS];
      logic [15:0] s_own[NUM_SLOTS];
      logic [3:0]  s_fifo[NUM_SLOTS][NUM_PROCS];
      int unsigned s_head[NUM_SLOTS];
      int unsigned s_len[NUM_SLOTS];
      int          errors;

      function void put(logic st, logic [1:0] act, logic [3:0] tgt, logic lst);
         rsp_word_type w;
         w.status = st; w.action = act; w.target_pid = tgt; w.last = lst;
         pending.push_back(w);
      endfunction

      function int find(logic [31:0] key);
         for (int s = 0; s < NUM_SLOTS; s++)
            if (s_valid[s] && s_key[s] == key) return s;
         return -1;
      endfunction

      function logic [3:0] pop(int s);
         logic [3:0] p;
         p = s_fifo[s][s_head[s]];
         s_head[s] = (s_head[s] + 1) % NUM_PROCS;
         s_len[s]--;
         return p;
      endfunction

      function void drop_one(int s, logic [3:0] p);
         int unsigned n;
         n = s_len[s];
         for (int i = 0; i < n; i++) begin
            if (s_fifo[s][(s_head[s] + i) % NUM_PROCS] == p) begin
               for (int j = i; j + 1 < n; j++)
                  s_fifo[s][(s_head[s] + j) % NUM_PROCS] =
                     s_fifo[s][(s_head[s] + j + 1) % NUM_PROCS];
               s_len[s] = n - 1;
               return;
            end
         end
      endfunction

      function void leave(int s, logic [3:0] p);
         if (s_refs[s] > 1) begin
            s_refs[s]--;
            s_own[s][p] = 1'b0;
         end else begin
            s_valid[s] = 0; s_len[s] = 0; s_head[s] = 0;
         end
      endfunction

      // note an accepted request word; append the words it should cause
      function void note_request(logic [2:0] fn, logic [31:0] key, logic [3:0] pid,
                                 logic [15:0] val, logic blk);
         int s;
         int unsigned v;
         v = val;
         s = find(key);
         case (fn)
            FUNC_OPEN: begin
               if (s >= 0) begin
                  if (s_own[s][pid]) begin put(1, ACT_NONE, 0, 1); return; end
                  s_own[s][pid] = 1'b1; s_refs[s]++;
                  put(0, ACT_NONE, 0, 1); return;
               end
               for (s = 0; s < NUM_SLOTS; s++) if (!s_valid[s]) break;
               if (s >= NUM_SLOTS) begin put(1, ACT_NONE, 0, 1); return; end
               s_valid[s] = 1; s_key[s] = key; s_count[s] = v; s_refs[s] = 1;
               s_own[s] = '0; s_own[s][pid] = 1'b1; s_head[s] = 0; s_len[s] = 0;
               put(0, ACT_NONE, 0, 1);
            end
            FUNC_CLOSE: begin
               if (s < 0) begin put(1, ACT_NONE, 0, 1); return; end
               leave(s, pid); put(0, ACT_NONE, 0, 1);
            end
            FUNC_WAIT: begin
               if (s < 0) begin put(1, ACT_NONE, 0, 1); return; end
               if (s_count[s] > 0) begin
                  s_count[s]--; put(0, ACT_NONE, 0, 1); return;
               end
               if (s_len[s] >= NUM_PROCS) begin put(1, ACT_NONE, 0, 1); return; end
               s_fifo[s][(s_head[s] + s_len[s]) % NUM_PROCS] = pid;
               s_len[s]++;
               put(0, ACT_BLOCK, pid, 1);
            end
            FUNC_POST: begin
               if (s < 0) begin put(1, ACT_NONE, 0, 1); return; end
               if (s_len[s] > 0) put(0, ACT_WAKE, pop(s), 0);
               else if (s_count[s] < 65535) s_count[s]++;
               put(0, ACT_NONE, 0, 1);
            end
            FUNC_RESET: begin
               if (s < 0) begin put(1, ACT_NONE, 0, 1); return; end
               while (s_len[s] > 0 && v > 0) begin
                  put(0, ACT_WAKE, pop(s), 0); v--;
               end
               s_count[s] = v;
               put(0, ACT_NONE, 0, 1);
            end
            FUNC_PURGE: begin
               for (int t = 0; t < NUM_SLOTS; t++) begin
                  if (!s_valid[t] || !s_own[t][pid]) continue;
                  if (blk) drop_one(t, pid);
                  leave(t, pid);
               end
               put(0, ACT_NONE, 0, 1);
            end
            default: put(1, ACT_NONE, 0, 1);
         endcase
      endfunction

      // check one accepted response word against the oldest prediction
      function void check_response(rsp_word_type got);
         rsp_word_type w;
         if (pending.size() == 0) begin
            $error("unexpected response word %p", got); errors++; return;
         end
         w = pending.pop_front();
         if (got.status !== w.status) begin
            $error("status: expected %0d actual %0d", w.status, got.status); errors++;
         end
         if (got.action !== w.action) begin
            $error("action: expected %0d actual %0d", w.action, got.action); errors++;
         end
         if (got.target_pid !== w.target_pid) begin
            $error("target_pid: expected %0d actual %0d", w.target_pid, got.target_pid);
            errors++;
         end
         if (got.last !== w.last) begin
            $error("last: expected %0d actual %0d", w.last, got.last); errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #10 clock = ~clock;

   cst_req_if req_if ();
   cst_rsp_if rsp_if ();

   counting_semaphore_table dut (.clock(clock), .reset(reset), .req_if(req_if),
                                 .rsp_if(rsp_if));

   sem_scoreboard sb = new();
   int unsigned cycles = 0;
   bit          drain_done = 0;
   logic [31:0] key_pool[8];

   initial begin
      req_if.valid = 1'b0; req_if.func = '0; req_if.sem_key = '0;
      req_if.pid = '0; req_if.count_value = '0; req_if.caller_blocked = 1'b0;
      rsp_if.ready = 1'b0;
   end

   // cycle limit: generous against ~420 words, long purges and slow response pace
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // response side: random stall per word, sometimes none
   initial begin : rsp_side
      rsp_word_type w;
      int gap;
      @(posedge clock iff !reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock iff rsp_if.valid);
         w.status = rsp_if.status; w.action = rsp_if.action;
         w.target_pid = rsp_if.target_pid; w.last = rsp_if.last;
         sb.check_response(w);
      end
   end

   // send one request word; hold valid over the wait for ready
   task automatic send_word(logic [2:0] fn, logic [31:0] key, logic [3:0] pid,
                            logic [15:0] val, logic blk, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1; req_if.func <= fn; req_if.sem_key <= key;
      req_if.pid <= pid; req_if.count_value <= val; req_if.caller_blocked <= blk;
      @(posedge clock iff req_if.ready);
      sb.note_request(fn, key, pid, val, blk);
   endtask

   task automatic send_random(bit burst);
      logic [2:0] fn;
      logic [15:0] val;
      int r;
      r = $urandom_range(0, 99);
      // mostly well-formed: wait/post on the small pool of live keys
      if (r < 18) fn = FUNC_OPEN;
      else if (r < 26) fn = FUNC_CLOSE;
      else if (r < 54) fn = FUNC_WAIT;
      else if (r < 76) fn = FUNC_POST;
      else if (r < 86) fn = FUNC_RESET;
      else if (r < 94) fn = FUNC_PURGE;
      else fn = 3'($urandom_range(6, 7));
      case ($urandom_range(0, 3))
         0: val = 16'($urandom);
         1: val = 16'hFFFF;
         default: val = 16'($urandom_range(0, 4));
      endcase
      send_word(fn, ($urandom_range(0, 15) == 0) ? $urandom : key_pool[$urandom_range(0, 7)],
                4'($urandom), val, 1'($urandom), burst);
   endtask

   initial begin : stim
      bit burst;
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h0; key_pool[1] = 32'hFFFF_FFFF;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes and the special cases
      send_word(FUNC_WAIT, 32'h1234, 4'd0, 16'd0, 1'b0, 0);     // key not found
      send_word(FUNC_OPEN, 32'h0, 4'd0, 16'd0, 1'b0, 0);
      send_word(FUNC_OPEN, 32'h0, 4'd0, 16'd5, 1'b0, 0);       // already owner
      send_word(FUNC_OPEN, 32'h0, 4'd15, 16'd0, 1'b0, 0);
      send_word(FUNC_WAIT, 32'h0, 4'd3, 16'd0, 1'b0, 0);       // blocks
      send_word(FUNC_WAIT, 32'h0, 4'd15, 16'd0, 1'b0, 0);
      send_word(FUNC_WAIT, 32'h0, 4'd3, 16'd0, 1'b0, 0);       // queued twice
      send_word(FUNC_POST, 32'h0, 4'd9, 16'd0, 1'b0, 0);       // wakes oldest
      send_word(FUNC_RESET, 32'h0, 4'd0, 16'd1, 1'b0, 0);      // wake one, count 0
      send_word(FUNC_PURGE, 32'h0, 4'd3, 16'd0, 1'b1, 0);      // non-owner purge
      send_word(FUNC_OPEN, 32'hFFFF_FFFF, 4'd7, 16'hFFFF, 1'b0, 0);
      send_word(FUNC_POST, 32'hFFFF_FFFF, 4'd7, 16'd0, 1'b0, 0); // saturates
      send_word(FUNC_WAIT, 32'hFFFF_FFFF, 4'd7, 16'd0, 1'b0, 0);
      send_word(3'd6, 32'h0, 4'd0, 16'd0, 1'b0, 0);
      send_word(3'd7, 32'hFFFF_FFFF, 4'd15, 16'hFFFF, 1'b1, 0);
      send_word(FUNC_CLOSE, 32'h0, 4'd9, 16'd0, 1'b0, 0);      // non-owner close
      send_word(FUNC_CLOSE, 32'h0, 4'd15, 16'd0, 1'b0, 0);     // frees, drops waiters
      send_word(FUNC_PURGE, 32'h0, 4'd7, 16'd0, 1'b1, 0);
      // fill the table, then one more new key
      for (int i = 0; i < 17; i++)
         send_word(FUNC_OPEN, 32'hA000_0000 + i, 4'(i), 16'd0, 1'b0, 1);
      // overfill one queue
      for (int i = 0; i < 17; i++)
         send_word(FUNC_WAIT, 32'hA000_0000, 4'(i), 16'd0, 1'b0, 1);
      send_word(FUNC_RESET, 32'hA000_0000, 4'd0, 16'hFFFF, 1'b0, 0); // 16 wakes
      for (int i = 0; i < 16; i++)
         send_word(FUNC_PURGE, 32'h0, 4'(i), 16'd0, 1'b1, 1);

      // random part in phases, some with no gaps at all
      for (int i = 0; i < 350; i++) begin
         if (i % 60 == 0) burst = ($urandom_range(0, 2) == 0);
         send_random(burst);
      end
      req_if.valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
